// File: rtl/core/cids_pkg.sv
// shared types, phase codes, status codes and signature table for the container id scanner
`timescale 1ns / 1ps
package cids_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] file_length;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grf_ident;
    } t_out;

    typedef enum logic [3:0] {
        PH_SIG    = 4'd0,
        PH_TAIL   = 4'd1,
        PH_MSIZE  = 4'd2,
        PH_MFF    = 4'd3,
        PH_COUNT  = 4'd4,
        PH_SIZE   = 4'd5,
        PH_TYPE   = 4'd6,
        PH_ACTION = 4'd7,
        PH_VER    = 4'd8,
        PH_IDENT  = 4'd9,
        PH_SKIP   = 4'd10,
        PH_RSKIP  = 4'd11,
        PH_RHEAD  = 4'd12
    } t_phase;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NO_MAGIC = 2'd1;
    localparam logic [1:0] ST_CORRUPT  = 2'd2;
    localparam logic [1:0] ST_NO_IDENT = 2'd3;

    localparam logic [7:0] TYPE_PSEUDO = 8'hFF;
    localparam logic [7:0] TYPE_V2_EXT = 8'hFD;
    localparam logic [7:0] MAGIC_BYTE  = 8'hFF;
    localparam logic [7:0] ACTION_ID   = 8'h08;
    localparam logic [7:0] RUN_LIMIT   = 8'h80;

    // version-2 signature, 10 bytes
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h00;
            4'd2:    v = 8'h47;
            4'd3:    v = 8'h52;
            4'd4:    v = 8'h46;
            4'd5:    v = 8'h82;
            4'd6:    v = 8'h0d;
            4'd7:    v = 8'h0a;
            4'd8:    v = 8'h1a;
            4'd9:    v = 8'h0a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/cids_scan.sv
// per-byte scanner state and next-state logic, one request a cycle while i_take is high
`timescale 1ns / 1ps
module cids_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  cids_pkg::t_in i_req,
    output logic          o_res_valid,
    output cids_pkg::t_out o_res
);
    import cids_pkg::*;

    t_phase             r_phase, n_phase;
    logic [31:0]        r_pos, n_pos;
    logic [31:0]        r_acc, n_acc;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_v2, n_v2;
    logic [31:0]        r_skip, n_skip;
    logic signed [32:0] r_sdr, n_sdr;
    logic               r_sent, n_sent;

    logic [7:0]  b;
    logic [31:0] len;
    logic        last;
    logic [31:0] acc_le;
    logic [1:0]  size_last;
    logic [32:0] end_pos;
    logic [31:0] skip_dec;
    logic [31:0] rec_rest;
    logic [7:0]  run_n;
    logic [5:0]  lit_n;
    logic [5:0]  tail_sh;
    logic        st_valid;
    logic [1:0]  st;
    logic [31:0] ident;

    always_comb begin
        b         = i_req.data_byte;
        len       = i_req.file_length;
        last      = ({1'b0, r_pos} + 33'd1) >= {1'b0, len};
        acc_le    = r_acc | ({24'h0, b} << {r_cnt, 3'b000});
        size_last = r_v2 ? 2'd3 : 2'd1;
        end_pos   = {1'b0, r_pos} + 33'd1 + {1'b0, acc_le};
        skip_dec  = r_skip - 32'd1;
        rec_rest  = r_sdr[31:0] - 32'd1;
        run_n     = (b == 8'h00) ? RUN_LIMIT : b;
        lit_n     = 6'd32 - {1'b0, b[7:3]};
        tail_sh   = 6'd0;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_v2    = r_v2;
        n_skip  = r_skip;
        n_sdr   = r_sdr;
        n_sent  = r_sent;

        st_valid = 1'b0;
        st       = ST_NO_IDENT;
        ident    = 32'h0;

        if (!r_sent) begin
            case (r_phase)
                PH_SIG: begin
                    if (r_pos == 32'd0) begin
                        if (b != 8'h00) begin
                            // not a signature: this byte opens the magic size
                            n_phase = PH_MSIZE;
                            n_acc   = {24'h0, b};
                            n_cnt   = 2'd1;
                        end else if (len <= 32'd10) begin
                            st_valid = 1'b1;
                            st       = ST_NO_MAGIC;
                        end
                    end else if (r_pos > 32'd9 || b != sig_byte(r_pos[3:0])) begin
                        st_valid = 1'b1;
                        st       = ST_NO_MAGIC;
                    end else if (r_pos == 32'd9) begin
                        n_v2    = 1'b1;
                        n_skip  = 32'd5;
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    n_skip = skip_dec;
                    if (skip_dec == 32'd0) begin
                        n_phase = PH_MSIZE;
                        n_acc   = 32'h0;
                        n_cnt   = 2'd0;
                    end
                end
                PH_MSIZE: begin
                    n_acc = acc_le;
                    if (r_cnt == size_last) begin
                        if (acc_le != 32'd4) begin
                            st_valid = 1'b1;
                            st       = ST_NO_MAGIC;
                        end else begin
                            n_phase = PH_MFF;
                        end
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_MFF: begin
                    if (b != MAGIC_BYTE) begin
                        st_valid = 1'b1;
                        st       = ST_NO_MAGIC;
                    end else begin
                        n_phase = PH_COUNT;
                        n_acc   = 32'h0;
                        n_cnt   = 2'd0;
                    end
                end
                PH_COUNT: begin
                    n_acc = acc_le;
                    if (r_cnt == 2'd3) begin
                        n_phase = PH_SIZE;
                        n_acc   = 32'h0;
                        n_cnt   = 2'd0;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_SIZE: begin
                    n_acc = acc_le;
                    if (r_cnt == size_last) begin
                        if (acc_le == 32'd0) begin
                            st_valid = 1'b1;
                            st       = ST_NO_IDENT;
                        end else if (end_pos > {1'b0, len}) begin
                            st_valid = 1'b1;
                            st       = ST_CORRUPT;
                        end else begin
                            n_sdr   = $signed({1'b0, acc_le});
                            n_phase = PH_TYPE;
                        end
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_TYPE: begin
                    if (b == TYPE_PSEUDO) begin
                        n_phase = PH_ACTION;
                    end else if (r_v2 && b == TYPE_V2_EXT) begin
                        n_skip  = 32'd4;
                        n_phase = PH_SKIP;
                    end else if (!r_v2) begin
                        if (b[1]) begin
                            if (rec_rest == 32'd0) begin
                                n_phase = PH_SIZE;
                                n_acc   = 32'h0;
                                n_cnt   = 2'd0;
                            end else begin
                                n_skip  = rec_rest;
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            // run-length data, header bytes come off the budget first
                            n_sdr   = r_sdr - 33'sd8;
                            n_skip  = 32'd7;
                            n_phase = PH_RSKIP;
                        end
                    end else begin
                        st_valid = 1'b1;
                        st       = ST_NO_IDENT;
                    end
                end
                PH_ACTION: begin
                    if (b == ACTION_ID) begin
                        n_phase = PH_VER;
                    end else if (rec_rest == 32'd0) begin
                        n_phase = PH_SIZE;
                        n_acc   = 32'h0;
                        n_cnt   = 2'd0;
                    end else begin
                        n_skip  = rec_rest;
                        n_phase = PH_SKIP;
                    end
                end
                PH_VER: begin
                    n_phase = PH_IDENT;
                    n_acc   = 32'h0;
                    n_cnt   = 2'd0;
                end
                PH_IDENT: begin
                    n_acc = {r_acc[23:0], b};
                    if (r_cnt == 2'd3) begin
                        st_valid = 1'b1;
                        ident    = {r_acc[23:0], b};
                        st       = (ident != 32'h0) ? ST_FOUND : ST_NO_IDENT;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 32'd0) begin
                        n_phase = PH_SIZE;
                        n_acc   = 32'h0;
                        n_cnt   = 2'd0;
                    end
                end
                PH_RSKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 32'd0) begin
                        if (!r_sdr[32] && r_sdr != 33'sd0) begin
                            n_phase = PH_RHEAD;
                        end else begin
                            n_phase = PH_SIZE;
                            n_acc   = 32'h0;
                            n_cnt   = 2'd0;
                        end
                    end
                end
                PH_RHEAD: begin
                    if (b < RUN_LIMIT) begin
                        n_sdr  = r_sdr - $signed({25'h0, run_n});
                        n_skip = {24'h0, run_n};
                    end else begin
                        n_sdr  = r_sdr - $signed({27'h0, lit_n});
                        n_skip = 32'd1;
                    end
                    n_phase = PH_RSKIP;
                end
                default: begin
                    st_valid = 1'b1;
                    st       = ST_NO_IDENT;
                end
            endcase

            // file ends undecided: bytes past the end read as zero
            if (!st_valid && last) begin
                st_valid = 1'b1;
                case (n_phase)
                    PH_SIG, PH_TAIL, PH_MSIZE, PH_MFF: begin
                        st = ST_NO_MAGIC;
                    end
                    PH_SIZE: begin
                        st = (n_cnt != 2'd0 && n_acc != 32'h0) ? ST_CORRUPT : ST_NO_IDENT;
                    end
                    PH_IDENT: begin
                        if (n_cnt == 2'd0) begin
                            st = ST_NO_IDENT;
                        end else begin
                            tail_sh = {3'd4 - {1'b0, n_cnt}, 3'b000};
                            ident   = n_acc << tail_sh;
                            st      = (ident != 32'h0) ? ST_FOUND : ST_NO_IDENT;
                        end
                    end
                    default: begin
                        st = ST_NO_IDENT;
                    end
                endcase
            end
        end

        if (st_valid) begin
            n_sent = 1'b1;
        end

        if (last) begin
            n_phase = PH_SIG;
            n_pos   = 32'h0;
            n_acc   = 32'h0;
            n_cnt   = 2'd0;
            n_v2    = 1'b0;
            n_skip  = 32'h0;
            n_sdr   = 33'sd0;
            n_sent  = 1'b0;
        end else begin
            n_pos = r_pos + 32'd1;
        end

        o_res_valid      = i_take && st_valid;
        o_res.status     = st;
        o_res.grf_ident  = (st == ST_FOUND) ? ident : 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_pos   <= 32'h0;
            r_acc   <= 32'h0;
            r_cnt   <= 2'd0;
            r_v2    <= 1'b0;
            r_skip  <= 32'h0;
            r_sdr   <= 33'sd0;
            r_sent  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_v2    <= n_v2;
            r_skip  <= n_skip;
            r_sdr   <= n_sdr;
            r_sent  <= n_sent;
        end
    end

endmodule

// File: rtl/core/cids_obuf.sv
// result register with a skid stage that absorbs a result under output stall before the input is held off
`timescale 1ns / 1ps
module cids_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cids_pkg::t_out i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output cids_pkg::t_out o_data
);
    import cids_pkg::*;

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_out r_out_data, n_out_data;
    t_out r_skid_data, n_skid_data;
    logic pop;

    always_comb begin
        pop          = r_out_valid && !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            // input is held off while the skid holds a request
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// File: rtl/core/container_id_scanner_core.sv
// a result is registered in the output stage after the byte that decides it, or in the skid stage under stall
// throughput: one file byte per cycle while the skid stage is empty, set by the single-pass scanner state update
// at most one result per file; bytes after a result are taken and dropped
// the input stalls only while the output skid stage is occupied
// reset: synchronous active low, scanner returns to signature check, buffers empty
`timescale 1ns / 1ps
module container_id_scanner_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cids_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cids_pkg::t_out o_out_data
);
    import cids_pkg::*;

    logic take;
    logic res_valid;
    logic buf_full;
    t_out res;

    assign take       = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    cids_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req       (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cids_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
